// ===== rtl/ir_pulse_width_capture_unit_assert.svh =====
// Assertion macros for the IR pulse-width capture unit.
// Needs a clock named clk and an active-high reset named rst in the including scope.
`ifndef IR_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH
`define IR_PULSE_WIDTH_CAPTURE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPWC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipwc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipwc: next-cycle check failed");

`endif

// ===== rtl/ipwc_pkg.sv =====
// Shared types and constants for the IR pulse-width capture unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ipwc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [15:0] IDLE_LIMIT_RESET = 16'd50;
  localparam logic [23:0] REM_MAX = 24'hFFFFFF;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_ON      = 2'd2,
    CMD_OFF     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_LOW  = 3'd0,
    KIND_HIGH = 3'd1,
    KIND_EOS  = 3'd2,
    KIND_ON   = 3'd3,
    KIND_OFF  = 3'd4
  } kind_t;

  // One queued job: its first result, and a trailing high width when two is set.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] width;
    logic        two;
    logic [15:0] width2;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } enq_t;

endpackage

// ===== rtl/ipwc_front.sv =====
// Front part: accepts input items, keeps the receiver state and builds job descriptors.
// Depends on ipwc_pkg.
module ipwc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           cmd,
  input  logic [15:0]          rise_time,
  input  logic [15:0]          fall_time,
  input  logic [23:0]          on_duration,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  output ipwc_pkg::enq_t       enq,
  output logic                 active
);

  logic [15:0] idle_limit;
  logic [23:0] remaining;
  logic [15:0] last_fall;
  logic        fall_known;
  logic [15:0] idle;

  logic        active_next;
  logic [23:0] remaining_next;
  logic [15:0] last_fall_next;
  logic        fall_known_next;
  logic [15:0] idle_next;
  logic [15:0] idle_inc;
  logic [24:0] rem_sum;

  assign idle_inc = (idle < ipwc_pkg::IDLE_MAX) ? idle + 16'd1 : idle;
  assign rem_sum  = {1'b0, remaining} + {1'b0, on_duration};

  always_comb begin
    active_next     = active;
    remaining_next  = remaining;
    last_fall_next  = last_fall;
    fall_known_next = fall_known;
    idle_next       = idle;
    enq             = '0;
    enq.desc.kind   = ipwc_pkg::KIND_OFF;
    unique case (ipwc_pkg::cmd_t'(cmd))
      ipwc_pkg::CMD_CAPTURE: begin
        if (active) begin
          enq.valid = 1'b1;
          if (fall_known) begin
            enq.desc.kind   = ipwc_pkg::KIND_LOW;
            enq.desc.width  = rise_time - last_fall;
            enq.desc.two    = 1'b1;
            enq.desc.width2 = fall_time - rise_time;
          end else begin
            enq.desc.kind  = ipwc_pkg::KIND_HIGH;
            enq.desc.width = fall_time - rise_time;
          end
          last_fall_next  = fall_time;
          fall_known_next = 1'b1;
          idle_next       = '0;
        end
      end
      ipwc_pkg::CMD_TICK: begin
        if (active) begin
          if (remaining == '0) begin
            active_next   = 1'b0;
            idle_next     = '0;
            enq.valid     = 1'b1;
            enq.desc.kind = ipwc_pkg::KIND_OFF;
          end else begin
            remaining_next = remaining - 24'd1;
            if (fall_known) begin
              if (idle_inc > idle_limit) begin
                fall_known_next = 1'b0;
                idle_next       = '0;
                enq.valid       = 1'b1;
                enq.desc.kind   = ipwc_pkg::KIND_EOS;
              end else begin
                idle_next = idle_inc;
              end
            end
          end
        end
      end
      ipwc_pkg::CMD_ON: begin
        if (!active) begin
          active_next    = 1'b1;
          remaining_next = on_duration;
          idle_next      = '0;
        end else begin
          remaining_next = rem_sum[24] ? ipwc_pkg::REM_MAX : rem_sum[23:0];
        end
        enq.valid     = 1'b1;
        enq.desc.kind = ipwc_pkg::KIND_ON;
      end
      ipwc_pkg::CMD_OFF: begin
        active_next    = 1'b0;
        remaining_next = '0;
        idle_next      = '0;
        enq.valid      = 1'b1;
        enq.desc.kind  = ipwc_pkg::KIND_OFF;
      end
    endcase
    if (!accept) begin
      enq.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= ipwc_pkg::IDLE_LIMIT_RESET;
      active     <= 1'b0;
      remaining  <= '0;
      last_fall  <= '0;
      fall_known <= 1'b0;
      idle       <= '0;
    end else begin
      if (cfg_we) begin
        idle_limit <= cfg_wdata;
      end
      if (accept) begin
        active     <= active_next;
        remaining  <= remaining_next;
        last_fall  <= last_fall_next;
        fall_known <= fall_known_next;
        idle       <= idle_next;
      end
    end
  end

endmodule

// ===== rtl/ipwc_queue.sv =====
// Short job queue between the front and back parts, built from registers.
// Depends on ipwc_pkg.
module ipwc_queue #(
  parameter int DEPTH = ipwc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  ipwc_pkg::enq_t  enq,
  input  logic            deq,
  output logic            full,
  output logic            empty,
  output ipwc_pkg::desc_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ipwc_pkg::desc_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_deq;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign head   = slots[rd_ptr];
  assign do_deq = deq && !empty;

  always_ff @(posedge clk) begin
    if (enq.valid) begin
      slots[wr_ptr] <= enq.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (enq.valid && !do_deq) begin
        count <= count + CNT_W'(1);
      end else if (!enq.valid && do_deq) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ipwc_back.sv =====
// Back part: expands queued jobs into result beats held in an output register.
// Depends on ipwc_pkg.
module ipwc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  ipwc_pkg::desc_t head,
  output logic            deq,
  input  logic            pop,
  output logic            out_valid,
  output ipwc_pkg::kind_t out_kind,
  output logic [15:0]     out_width,
  output logic            out_last
);

  logic        sec_valid;
  logic [15:0] sec_width;
  logic        take;

  // The output register is free when it is empty or its beat leaves this cycle.
  assign take = !out_valid || pop;
  assign deq  = take && !sec_valid && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (take) begin
      if (sec_valid) begin
        out_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        sec_valid <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (sec_valid) begin
        out_kind  <= ipwc_pkg::KIND_HIGH;
        out_width <= sec_width;
        out_last  <= 1'b1;
      end else if (!q_empty) begin
        out_kind  <= head.kind;
        out_width <= head.width;
        out_last  <= !head.two;
        sec_width <= head.width2;
      end
    end
  end

endmodule

// ===== rtl/ir_pulse_width_capture_unit.sv =====
// Top level of the IR pulse-width capture unit: front, job queue and back.
// Depends on ipwc_pkg, ipwc_front, ipwc_queue, ipwc_back and the assertion header.
//
//   Channel   Handshake        Payload
//   input     push / full      cmd, rise_time, fall_time, on_duration
//   result    empty / pop      kind, width, last
//   config    cfg_we           cfg_wdata (idle_limit_ms)
//
// One input item is accepted per cycle while the job queue has room.
// A result beat leaves per cycle while pop is held; a capture with a known
// falling edge gives two beats, so the back part's output register sets the
// sustained rate for such items. Results pass a queue slot, then the output register.
// Reset is synchronous; it empties the queue and clears the receiver state.
// A stalled result side fills the queue, after which full holds off the input.
module ir_pulse_width_capture_unit #(
  parameter int QUEUE_DEPTH = ipwc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [15:0] rise_time,
  input  logic [15:0] fall_time,
  input  logic [23:0] on_duration,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [15:0] width,
  output logic        last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  ipwc_pkg::enq_t  enq;
  ipwc_pkg::desc_t head;
  ipwc_pkg::kind_t out_kind;
  logic            accept;
  logic            q_empty;
  logic            deq;
  logic            out_valid;
  logic            front_active;

  assign accept = push && !full;
  assign empty  = !out_valid;
  assign kind   = out_kind;

  ipwc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .rise_time   (rise_time),
    .fall_time   (fall_time),
    .on_duration (on_duration),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .enq         (enq),
    .active      (front_active)
  );

  ipwc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .enq   (enq),
    .deq   (deq),
    .full  (full),
    .empty (q_empty),
    .head  (head)
  );

  ipwc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .deq       (deq),
    .pop       (pop),
    .out_valid (out_valid),
    .out_kind  (out_kind),
    .out_width (width),
    .out_last  (last)
  );

`include "ir_pulse_width_capture_unit_assert.svh"

  // A low width is always followed by its high width as the next beat.
  `IPWC_ASSERT_NEXT(a_pair_follows, !empty && pop && !last, !empty && kind == ipwc_pkg::KIND_HIGH)
  `IPWC_ASSERT_SAME(a_low_not_last, !empty && kind == ipwc_pkg::KIND_LOW, !last)
  `IPWC_ASSERT_NEXT(a_on_opens, push && !full && cmd == ipwc_pkg::CMD_ON, front_active)

endmodule
